### rtl/core/sq8l2_pkg.sv
// shared types and constants for the sq8 squared l2 distance core
`default_nettype none

package sq8l2_pkg;

  typedef enum logic [1:0] {
    CMD_QUERY = 2'd0,
    CMD_MIN   = 2'd1,
    CMD_STEP  = 2'd2,
    CMD_CODE  = 2'd3
  } cmd_t;

  localparam int VAL_W    = 32;
  localparam int CODE_W   = 8;
  localparam int DIMS_W   = 11;
  localparam int IDX_W    = 10;
  localparam int SQ_W     = 47;
  localparam int SUM_W    = 50;
  localparam int DIST_W   = 63;
  localparam int VNUM_W   = 16;
  localparam logic [DIMS_W-1:0] DIMS_RESET = 11'd128;
  localparam logic [DIST_W-1:0] DIST_MAX   = {DIST_W{1'b1}};

  // per-stage control that travels beside the lane data
  typedef struct packed {
    logic valid;
    logic last;
  } ctl_t;

endpackage

`default_nettype wire

### rtl/core/sq8u_l2_distance_per_dim_scale_core.sv
// Squared L2 distance between a stored query and sq8 code vectors.
// Input stream s_*: s_tuser carries the command. Load commands (query, min,
// step) write one signed Q16.16 entry at entry_index into the lane stores;
// code words carry LANES codes for the next dimensions of the current vector.
// Dimension d lives in lane d mod LANES, so every lane reads its own store
// bank for each code word and all lanes rebuild, diff and square in parallel.
// One item is accepted per clock while s_tready is high; loads and code words
// may be mixed freely. After the code word that covers the last dimension in
// use, the result (distance, saturation flag, vector number) passes the bank,
// lane and merge registers and is held in an output register on m_*.
// cfg_we/cfg_wdata set the dimension count; write it only while idle.
// When the receiver stalls, code words keep flowing until a second finished
// vector reaches the merge stage; then s_tready drops until m_tready.
// Reset clears the accumulator, dimension position, flag and vector count
// and sets the dimension count to 128. Store contents are not cleared and
// must be loaded before use.
`default_nettype none

module sq8u_l2_distance_per_dim_scale_core
  import sq8l2_pkg::*;
#(
  parameter int MAX_DIM = 1024,
  parameter int LANES   = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [10:0]  cfg_wdata,   // dims_in_use
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [111:0] s_tdata,     // entry_index, entry_value, code_word
  input  wire logic [1:0]   s_tuser,     // cmd
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [79:0]       m_tdata,     // distance, vector_number
  output logic              m_tuser      // saturated
);

  localparam int BANK_DEPTH = (MAX_DIM + LANES - 1) / LANES;
  localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int LW         = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int RECIP      = (65536 + LANES - 1) / LANES;
  localparam int DIM_CLAMP  = (MAX_DIM > 2047) ? 2047 : MAX_DIM;

  logic [IDX_W-1:0]        entry_index;
  logic signed [VAL_W-1:0] entry_value;
  logic [63:0]             code_word;
  cmd_t                    cmd;

  assign entry_index = s_tdata[9:0];
  assign entry_value = s_tdata[41:10];
  assign code_word   = s_tdata[105:42];
  assign cmd         = cmd_t'(s_tuser);

  logic [DIMS_W-1:0] dims_in_use;
  logic [DIMS_W-1:0] dims;

  always_ff @(posedge clk) begin
    if (rst) begin
      dims_in_use <= DIMS_RESET;
    end else if (cfg_we) begin
      dims_in_use <= cfg_wdata;
    end
  end

  always_comb begin
    if (dims_in_use == '0) begin
      dims = 11'd1;
    end else if (dims_in_use > DIMS_W'(DIM_CLAMP)) begin
      dims = DIMS_W'(DIM_CLAMP);
    end else begin
      dims = dims_in_use;
    end
  end

  logic en;
  logic fire;
  logic code_fire;
  logic load_fire;

  assign s_tready  = en;
  assign fire      = s_tvalid & en;
  assign code_fire = fire && (cmd == CMD_CODE);
  assign load_fire = fire && (cmd != CMD_CODE);

  // load address split: bank = index mod LANES, row = index / LANES
  logic [26:0]      div_prod;
  logic [IDX_W-1:0] row_idx;
  logic [IDX_W-1:0] rem_idx;
  logic [LW-1:0]    bank_sel;
  logic             idx_ok;

  assign div_prod = 27'(entry_index) * 27'(RECIP);
  assign row_idx  = div_prod[25:16];
  assign rem_idx  = entry_index - IDX_W'(row_idx * IDX_W'(LANES));
  assign bank_sel = rem_idx[LW-1:0];
  assign idx_ok   = 32'(entry_index) < 32'(MAX_DIM);

  // dimension position of the next code word and its store row
  logic [DIMS_W-1:0] pos;
  logic [AW-1:0]     row;
  logic [DIMS_W:0]   pos_plus;
  logic              word_last;

  assign pos_plus  = 12'(pos) + 12'(LANES);
  assign word_last = pos_plus >= 12'(dims);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      row <= '0;
    end else if (code_fire) begin
      if (word_last) begin
        pos <= '0;
        row <= '0;
      end else begin
        pos <= pos_plus[DIMS_W-1:0];
        row <= row + AW'(1);
      end
    end
  end

  ctl_t ctl1;
  ctl_t ctl2;
  ctl_t ctl3;
  ctl_t ctl4;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
      ctl2 <= '0;
      ctl3 <= '0;
      ctl4 <= '0;
    end else if (en) begin
      ctl1.valid <= code_fire;
      ctl1.last  <= word_last;
      ctl2       <= ctl1;
      ctl3       <= ctl2;
      ctl4       <= ctl3;
    end
  end

  logic [SQ_W-1:0] lane_sq  [LANES];
  logic            lane_sat [LANES];

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    logic [CODE_W-1:0]       code1;
    logic                    on1;
    logic signed [VAL_W-1:0] query1;
    logic signed [VAL_W-1:0] min1;
    logic signed [VAL_W-1:0] step1;

    always_ff @(posedge clk) begin
      if (en) begin
        code1 <= code_word[CODE_W*k +: CODE_W];
        on1   <= (12'(pos) + 12'(k)) < 12'(dims);
      end
    end

    sq8l2_bank #(
      .DEPTH (BANK_DEPTH),
      .AW    (AW)
    ) u_bank (
      .clk     (clk),
      .wr_en   (load_fire && idx_ok && (bank_sel == LW'(k))),
      .wr_cmd  (cmd),
      .wr_addr (AW'(row_idx)),
      .wr_data (entry_value),
      .rd_en   (code_fire),
      .rd_addr (row),
      .query   (query1),
      .min_val (min1),
      .step    (step1)
    );

    sq8l2_lane u_lane (
      .clk     (clk),
      .en      (en),
      .code    (code1),
      .lane_on (on1),
      .query   (query1),
      .min_val (min1),
      .step    (step1),
      .sq      (lane_sq[k]),
      .sat     (lane_sat[k])
    );
  end

  logic [DIST_W-1:0] distance;
  logic              saturated;
  logic [VNUM_W-1:0] vector_number;

  sq8l2_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk           (clk),
    .rst           (rst),
    .ctl_in        (ctl4),
    .lane_sq       (lane_sq),
    .lane_sat      (lane_sat),
    .advance       (en),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .distance      (distance),
    .saturated     (saturated),
    .vector_number (vector_number)
  );

  assign m_tdata = {1'b0, vector_number, distance};
  assign m_tuser = saturated;

endmodule

`default_nettype wire

### rtl/core/sq8l2_bank.sv
// one lane's slice of the query, min and step stores
`default_nettype none

module sq8l2_bank
  import sq8l2_pkg::*;
#(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  wire logic                    clk,
  input  wire logic                    wr_en,
  input  wire cmd_t                    wr_cmd,
  input  wire logic [AW-1:0]           wr_addr,
  input  wire logic signed [VAL_W-1:0] wr_data,
  input  wire logic                    rd_en,
  input  wire logic [AW-1:0]           rd_addr,
  output logic signed [VAL_W-1:0]      query,
  output logic signed [VAL_W-1:0]      min_val,
  output logic signed [VAL_W-1:0]      step
);

  logic signed [VAL_W-1:0] query_mem [DEPTH];
  logic signed [VAL_W-1:0] min_mem   [DEPTH];
  logic signed [VAL_W-1:0] step_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      case (wr_cmd)
        CMD_QUERY: query_mem[wr_addr] <= wr_data;
        CMD_MIN:   min_mem[wr_addr]   <= wr_data;
        CMD_STEP:  step_mem[wr_addr]  <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      query   <= query_mem[rd_addr];
      min_val <= min_mem[rd_addr];
      step    <= step_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/sq8l2_lane.sv
// one distance lane: rebuild, saturating difference and truncated square
`default_nettype none

module sq8l2_lane
  import sq8l2_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic [CODE_W-1:0]       code,
  input  wire logic                    lane_on,
  input  wire logic signed [VAL_W-1:0] query,
  input  wire logic signed [VAL_W-1:0] min_val,
  input  wire logic signed [VAL_W-1:0] step,
  output logic [SQ_W-1:0]              sq,
  output logic                         sat
);

  localparam logic signed [42:0] DIFF_MAX = 43'sd2147483647;
  localparam logic signed [42:0] DIFF_MIN = -43'sd2147483648;

  logic signed [40:0]      prod_full;
  logic signed [40:0]      prod2;
  logic signed [VAL_W-1:0] min2;
  logic signed [VAL_W-1:0] query2;
  logic                    on2;
  logic signed [42:0]      rec;
  logic signed [42:0]      diff;
  logic                    over_hi;
  logic                    over_lo;
  logic [VAL_W-1:0]        diff_clamp;
  logic [VAL_W-1:0]        diff3;
  logic                    sat3;
  logic [VAL_W-1:0]        mag;
  logic [63:0]             sq_full;

  assign prod_full = 41'(signed'({1'b0, code})) * 41'(step);

  always_ff @(posedge clk) begin
    if (en) begin
      prod2  <= prod_full;
      min2   <= min_val;
      query2 <= query;
      on2    <= lane_on;
    end
  end

  always_comb begin
    rec     = 43'(min2) + 43'(prod2);
    diff    = 43'(query2) - rec;
    over_hi = diff > DIFF_MAX;
    over_lo = diff < DIFF_MIN;
    if (!on2) begin
      diff_clamp = '0;
    end else if (over_hi) begin
      diff_clamp = 32'h7fff_ffff;
    end else if (over_lo) begin
      diff_clamp = 32'h8000_0000;
    end else begin
      diff_clamp = diff[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff3 <= diff_clamp;
      sat3  <= on2 & (over_hi | over_lo);
    end
  end

  // magnitude of the most negative value still fits as unsigned
  assign mag     = diff3[VAL_W-1] ? (~diff3 + 32'd1) : diff3;
  assign sq_full = 64'(mag) * 64'(mag);

  always_ff @(posedge clk) begin
    if (en) begin
      sq  <= sq_full[16 +: SQ_W];
      sat <= sat3;
    end
  end

endmodule

`default_nettype wire

### rtl/core/sq8l2_merge.sv
// lane sum, saturating accumulator and result register
`default_nettype none

module sq8l2_merge
  import sq8l2_pkg::*;
#(
  parameter int LANES = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ctl_t              ctl_in,
  input  wire logic [SQ_W-1:0]   lane_sq [LANES],
  input  wire logic              lane_sat [LANES],
  output logic                   advance,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [DIST_W-1:0]      distance,
  output logic                   saturated,
  output logic [VNUM_W-1:0]      vector_number
);

  logic [SUM_W-1:0]  sum_lanes;
  logic              sat_lanes;
  ctl_t              ctl5;
  logic [SUM_W-1:0]  sum5;
  logic              sat5;
  logic [DIST_W-1:0] acc;
  logic              seen;
  logic [VNUM_W-1:0] vcount;
  logic [63:0]       total;
  logic              over;
  logic [DIST_W-1:0] acc_next;
  logic              seen_next;
  logic              finish;

  always_comb begin
    sum_lanes = '0;
    sat_lanes = 1'b0;
    for (int k = 0; k < LANES; k++) begin
      sum_lanes = sum_lanes + SUM_W'(lane_sq[k]);
      sat_lanes = sat_lanes | lane_sat[k];
    end
  end

  // hold only if a finished vector meets a full, stalled result register
  assign advance = !(ctl5.valid && ctl5.last && m_tvalid && !m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl5 <= '0;
    end else if (advance) begin
      ctl5 <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sum5 <= sum_lanes;
      sat5 <= sat_lanes;
    end
  end

  // squares are never negative, so one clamp covers the lane adds in order
  assign total     = 64'(sum5) + 64'(acc);
  assign over      = total[63];
  assign acc_next  = over ? DIST_MAX : total[DIST_W-1:0];
  assign seen_next = seen | sat5 | over;
  assign finish    = advance && ctl5.valid && ctl5.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc    <= '0;
      seen   <= 1'b0;
      vcount <= '0;
    end else if (advance && ctl5.valid) begin
      if (ctl5.last) begin
        acc    <= '0;
        seen   <= 1'b0;
        vcount <= vcount + 16'd1;
      end else begin
        acc  <= acc_next;
        seen <= seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      distance      <= acc_next;
      saturated     <= seen_next;
      vector_number <= vcount + 16'd1;
    end
  end

endmodule

`default_nettype wire

### test/tb.sv
// self-checking testbench for the sq8 squared l2 distance core
`timescale 1ns / 1ps

module tb;
  import sq8l2_pkg::*;

  localparam int MAX_DIM = 1024;
  localparam int LANES = 8;
  localparam int IDLE_LIMIT = 4000;
  localparam longint unsigned SUM_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    cmd_t        cmd;
    logic [9:0]  idx;
    logic [31:0] val;
    logic [63:0] word;
  } stim_item_t;

  typedef struct packed {
    logic [62:0] distance;
    logic        saturated;
    logic [15:0] vnum;
  } dist_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [10:0]  cfg_wdata = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [111:0] s_tdata = '0;    // entry_index, entry_value, code_word
  logic [1:0]   s_tuser = '0;    // cmd
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [79:0]  m_tdata;         // distance, vector_number
  logic         m_tuser;         // saturated

  sq8u_l2_distance_per_dim_scale_core dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #5 clk = ~clk;

  stim_item_t   send_queue[$];
  dist_result_t dist_expected[$];
  int           error_count = 0;

  // predictor state
  logic signed [31:0] query_mem [MAX_DIM];
  logic signed [31:0] min_mem [MAX_DIM];
  logic signed [31:0] step_mem [MAX_DIM];
  longint unsigned    sum_acc = 0;
  int                 dim_pos = 0;
  logic               sat_seen = 1'b0;
  logic [15:0]        vec_count = '0;
  logic [10:0]        dims_reg = DIMS_RESET;

  // which store entries the stimulus has written so far
  bit loaded [3][MAX_DIM];

  function automatic int clamp_dims(int v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic predict_item(cmd_t c, logic [9:0] idx, logic [31:0] val, logic [63:0] word);
    int              dlim;
    longint          rec;
    longint          diff;
    longint unsigned mag;
    longint unsigned sq;
    dist_result_t    res;
    case (c)
      CMD_QUERY: query_mem[idx] = val;
      CMD_MIN:   min_mem[idx] = val;
      CMD_STEP:  step_mem[idx] = val;
      default: begin
        dlim = clamp_dims(dims_reg);
        for (int k = 0; k < LANES; k++) begin
          if (dim_pos < dlim) begin
            rec = longint'(min_mem[dim_pos]) + longint'({56'd0, word[8*k +: 8]})
                  * longint'(step_mem[dim_pos]);
            diff = longint'(query_mem[dim_pos]) - rec;
            if (diff > 64'sh7FFF_FFFF) begin
              diff = 64'sh7FFF_FFFF;
              sat_seen = 1'b1;
            end else if (diff < -64'sh8000_0000) begin
              diff = -64'sh8000_0000;
              sat_seen = 1'b1;
            end
            mag = (diff < 0) ? longint'(-diff) : longint'(diff);
            sq = (mag * mag) >> 16;
            if (sq > SUM_LIMIT - sum_acc) begin
              sum_acc = SUM_LIMIT;
              sat_seen = 1'b1;
            end else begin
              sum_acc += sq;
            end
            dim_pos++;
          end
        end
        if (dim_pos >= dlim) begin
          vec_count++;
          res.distance = sum_acc[62:0];
          res.saturated = sat_seen;
          res.vnum = vec_count;
          dist_expected.push_back(res);
          sum_acc = 0;
          dim_pos = 0;
          sat_seen = 1'b0;
        end
      end
    endcase
  endtask

  task automatic check_result();
    dist_result_t want;
    if (dist_expected.size() == 0) begin
      report_mismatch("result with nothing expected", m_tdata[62:0], 0);
    end else begin
      want = dist_expected.pop_front();
      if (m_tdata[62:0] !== want.distance)
        report_mismatch("distance", m_tdata[62:0], want.distance);
      if (m_tuser !== want.saturated)
        report_mismatch("saturated", m_tuser, want.saturated);
      if (m_tdata[78:63] !== want.vnum)
        report_mismatch("vector_number", m_tdata[78:63], want.vnum);
    end
  endtask

  // monitor: predict on every accepted item, check every accepted result
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        predict_item(cmd_t'(s_tuser), s_tdata[9:0], s_tdata[41:10], s_tdata[105:42]);
      if (m_tvalid && m_tready)
        check_result();
    end
  end

  // driver: bursts of random length, random gaps, valid held until accepted
  int         burst_left;
  int         gap_left;
  stim_item_t nxt;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (send_queue.size() == 0) begin
        s_tvalid <= 1'b0;
      end else begin
        nxt = send_queue.pop_front();
        s_tdata <= {6'd0, nxt.word, nxt.val, nxt.idx};
        s_tuser <= nxt.cmd;
        s_tvalid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 3) == 0) ? 150 : $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // receiver: stall pattern of its own plus one long hold-off
  int rx_count;
  int rx_hold;
  int rx_mode;
  int rx_mode_left;
  bit hold_done;
  int hold_at = 32'h7FFF_FFFF;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_count = 0;
      rx_hold = 0;
      rx_mode = 0;
      rx_mode_left = 0;
      hold_done = 0;
    end else begin
      if (m_tvalid && m_tready) rx_count++;
      if (!hold_done && rx_count >= hold_at) begin
        rx_hold = 300;
        hold_done = 1;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_tready <= 1'b0;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode = $urandom_range(0, 2);
          rx_mode_left = $urandom_range(10, 80);
        end else begin
          rx_mode_left--;
        end
        case (rx_mode)
          0: m_tready <= 1'b1;
          1: m_tready <= $urandom_range(0, 1);
          default: m_tready <= (rx_mode_left % 4 != 0);
        endcase
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // mostly modest values so sums stay meaningful, extremes now and then
  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 6))
      0: return $urandom;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'($signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000);
      4: return 32'($signed($urandom_range(0, 32'h0000_2000)) - 32'sh0000_1000);
      default: return 32'($signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000);
    endcase
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic push_load(cmd_t c, int idx, logic [31:0] v);
    stim_item_t it;
    it.cmd = c;
    it.idx = idx[9:0];
    it.val = v;
    it.word = rand_word();
    send_queue.push_back(it);
    loaded[int'(c)][idx] = 1;
  endtask

  task automatic push_code(logic [63:0] w);
    stim_item_t it;
    it.cmd = CMD_CODE;
    it.idx = 10'($urandom);
    it.val = $urandom;
    it.word = w;
    send_queue.push_back(it);
  endtask

  // every entry a vector of n dimensions reads gets written first
  task automatic cover_dims(int n);
    for (int d = 0; d < n; d++) begin
      if (!loaded[0][d]) push_load(CMD_QUERY, d, rand_value());
      if (!loaded[1][d]) push_load(CMD_MIN, d, rand_value());
      if (!loaded[2][d]) push_load(CMD_STEP, d, rand_value());
    end
  endtask

  // an item popped at the same edge may not show as valid yet, so check twice
  task automatic wait_drained();
    do begin
      while (send_queue.size() != 0 || s_tvalid || dist_expected.size() != 0)
        @(posedge clk);
      // partial vectors may still be in flight without any result
      repeat (12) @(posedge clk);
    end while (send_queue.size() != 0 || s_tvalid || dist_expected.size() != 0);
  endtask

  task automatic set_dims(int v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= v[10:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    dims_reg = v[10:0];
    @(posedge clk);
  endtask

  initial begin
    int d;
    int n_items;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset dimension count, extremes on the first two dimensions
    push_load(CMD_QUERY, 0, 32'h7FFF_FFFF);
    push_load(CMD_MIN, 0, 32'h8000_0000);
    push_load(CMD_STEP, 0, 32'h7FFF_FFFF);
    push_load(CMD_QUERY, 1, 32'h8000_0000);
    push_load(CMD_MIN, 1, 32'h7FFF_FFFF);
    push_load(CMD_STEP, 1, 32'h7FFF_FFFF);
    push_load(CMD_STEP, 1023, 32'h0000_0000);
    cover_dims(128);
    push_code(64'h0);
    push_code('1);
    push_code(64'hFF00_FF00_FF00_FF00);
    for (int i = 0; i < 29; i++) push_code(rand_word());

    // zero count acts as one
    set_dims(0);
    push_code('1);
    push_code(64'h0);
    // lanes past the last dimension ignored
    set_dims(3);
    push_code(rand_word());
    push_code(rand_word());
    // count lowered below the position mid-vector
    set_dims(20);
    push_code(rand_word());
    push_code(rand_word());
    set_dims(5);
    push_code(rand_word());
    push_code(rand_word());

    // random phases, mostly short vectors with loads mixed in
    for (int ph = 0; ph < 7; ph++) begin
      // short vectors during the long hold-off so the block fills up
      case ((ph == 1) ? 0 : $urandom_range(0, 5))
        0: d = $urandom_range(1, 8);
        1: d = ph == 6 ? 128 : 64;
        default: d = $urandom_range(1, 40);
      endcase
      set_dims(d);
      cover_dims(clamp_dims(d));
      if (ph == 1) hold_at = rx_count + 3;
      n_items = 36;
      for (int i = 0; i < n_items; i++) begin
        if ($urandom_range(0, 3) != 0) begin
          push_code(rand_word());
        end else if ($urandom_range(0, 2) == 0) begin
          push_load(cmd_t'($urandom_range(0, 2)), $urandom_range(0, MAX_DIM - 1), rand_value());
        end else begin
          push_load(cmd_t'($urandom_range(0, 2)), $urandom_range(0, clamp_dims(d) - 1),
                    rand_value());
        end
      end
      // finish the open vector so the phase drains
      for (int i = 0; i < (clamp_dims(d) + LANES - 1) / LANES; i++) push_code(rand_word());
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (dist_expected.size() != 0)
      report_mismatch("results never seen", 0, dist_expected.size());
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
